// ----- sv/run_class_pattern_detector_defines.svh -----
// ----------------------------------------------------------------------------
// run_class_pattern_detector_defines
// Assertion macros used by the detector top level.
// ----------------------------------------------------------------------------
`ifndef RUN_CLASS_PATTERN_DETECTOR_DEFINES_SVH
`define RUN_CLASS_PATTERN_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCPD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCPD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rcpd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcpd_pkg
// Types, register map, reset values and helper functions for the detector.
// ----------------------------------------------------------------------------
package rcpd_pkg;

    localparam int PIXEL_W       = 8;
    localparam int CODE_W        = 2;
    localparam int PATTERN_SLOTS = 5;
    localparam int PATTERN_W     = CODE_W * PATTERN_SLOTS;
    localparam int CFG_DATA_W    = PATTERN_W;

    typedef logic [PIXEL_W-1:0]    pixel_t;
    typedef logic [CODE_W-1:0]     code_t;
    typedef logic [PATTERN_W-1:0]  pattern_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [1:0]            cfg_index_t;

    // register map
    localparam cfg_index_t REG_LEVEL_DARK   = 2'd0;
    localparam cfg_index_t REG_LEVEL_MID    = 2'd1;
    localparam cfg_index_t REG_LEVEL_BRIGHT = 2'd2;
    localparam cfg_index_t REG_PATTERN_CODE = 2'd3;

    localparam pixel_t   LEVEL_DARK_RST   = 8'd0;
    localparam pixel_t   LEVEL_MID_RST    = 8'd128;
    localparam pixel_t   LEVEL_BRIGHT_RST = 8'd255;
    localparam pattern_t PATTERN_RST      = 10'd493;

    // run class codes
    localparam code_t CODE_NONE   = 2'd0;
    localparam code_t CODE_DARK   = 2'd1;
    localparam code_t CODE_MID    = 2'd2;
    localparam code_t CODE_BRIGHT = 2'd3;

    // bright beats mid beats dark when levels coincide
    function automatic code_t classify(input pixel_t v, input pixel_t lvl_dark,
                                       input pixel_t lvl_mid, input pixel_t lvl_bright);
        code_t c;
        priority if (v == lvl_bright) begin
            c = CODE_BRIGHT;
        end else if (v == lvl_mid) begin
            c = CODE_MID;
        end else if (v == lvl_dark) begin
            c = CODE_DARK;
        end else begin
            c = CODE_NONE;
        end
        return c;
    endfunction

    // slots past the stored five read as code none
    function automatic code_t pattern_slot(input pattern_t pat, input int k);
        code_t c;
        if (k >= PATTERN_SLOTS) begin
            c = CODE_NONE;
        end else begin
            c = pat[CODE_W*k +: CODE_W];
        end
        return c;
    endfunction

endpackage

// ----- sv/rcpd_close.sv -----
// ----------------------------------------------------------------------------
// rcpd_close
// Closes one run: classifies its value, shifts the code into the window,
// bumps the fill count and updates the sticky match flag.
// ----------------------------------------------------------------------------
module rcpd_close #(
    parameter int PATTERN_LEN = 5,
    parameter int FILL_W      = $clog2(PATTERN_LEN + 1)
) (
    input  logic [rcpd_pkg::CODE_W*PATTERN_LEN-1:0] win_in,
    input  logic [FILL_W-1:0]                       fill_in,
    input  logic                                    found_in,
    input  rcpd_pkg::pixel_t                        run_value,
    input  rcpd_pkg::pixel_t                        level_dark,
    input  rcpd_pkg::pixel_t                        level_mid,
    input  rcpd_pkg::pixel_t                        level_bright,
    input  rcpd_pkg::pattern_t                      pattern_code,
    output logic [rcpd_pkg::CODE_W*PATTERN_LEN-1:0] win_out,
    output logic [FILL_W-1:0]                       fill_out,
    output logic                                    found_out
);
    import rcpd_pkg::*;

    localparam int WIN_W = CODE_W * PATTERN_LEN;

    code_t new_code;
    logic  all_eq;
    logic  full;

    assign new_code = classify(run_value, level_dark, level_mid, level_bright);

    // slot 0 is the oldest code; new code enters at the top
    assign win_out  = {new_code, win_in[WIN_W-1:CODE_W]};
    assign fill_out = (fill_in < FILL_W'(PATTERN_LEN)) ? fill_in + 1'b1 : fill_in;
    assign full     = (fill_out == FILL_W'(PATTERN_LEN));

    always_comb begin
        all_eq = 1'b1;
        for (int k = 0; k < PATTERN_LEN; k++) begin
            if (win_out[CODE_W*k +: CODE_W] != pattern_slot(pattern_code, k)) begin
                all_eq = 1'b0;
            end
        end
    end

    assign found_out = found_in | (full & all_eq);

endmodule

// ----- sv/run_class_pattern_detector.sv -----
// ----------------------------------------------------------------------------
// run_class_pattern_detector
// The last pixel word is held in the input register, then its result word in the
// result register. Throughput: one pixel word per cycle; input
// stalls only while a last-pixel word waits behind an unaccepted result.
// Reset clears the run state and loads the default levels and pattern.
// ----------------------------------------------------------------------------
`include "run_class_pattern_detector_defines.svh"

module run_class_pattern_detector #(
    parameter int PATTERN_LEN = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rcpd_pkg::pixel_t      s_pixel_value,
    input  logic                  s_last_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_pattern_found,
    input  logic                  cfg_wr_en,
    input  rcpd_pkg::cfg_index_t  cfg_index,
    input  rcpd_pkg::cfg_data_t   cfg_wdata
);
    import rcpd_pkg::*;

    localparam int WIN_W  = CODE_W * PATTERN_LEN;
    localparam int FILL_W = $clog2(PATTERN_LEN + 1);

    // configuration
    pixel_t   level_dark_reg, level_bright_reg, level_mid_reg;
    pattern_t pattern_code_reg;

    // input register
    logic   stg_valid_reg;
    pixel_t stg_pixel_reg;
    logic   stg_last_reg;

    // run state
    pixel_t            run_value_reg, run_value_next;
    logic              run_open_reg, run_open_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              found_reg, found_next;

    // result register
    logic m_valid_reg;
    logic m_found_reg;

    logic              out_free, stg_advance, close_prev;
    logic [WIN_W-1:0]  win_a, win_mid, win_b;
    logic [FILL_W-1:0] fill_a, fill_mid, fill_b;
    logic              found_a, found_mid, found_b;

    assign out_free    = !m_valid_reg || m_ready;
    assign stg_advance = stg_valid_reg && (!stg_last_reg || out_free);
    assign s_ready     = !stg_valid_reg || stg_advance;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_dark_reg   <= LEVEL_DARK_RST;
            level_mid_reg    <= LEVEL_MID_RST;
            level_bright_reg <= LEVEL_BRIGHT_RST;
            pattern_code_reg <= PATTERN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LEVEL_DARK:   level_dark_reg   <= cfg_wdata[PIXEL_W-1:0];
                REG_LEVEL_MID:    level_mid_reg    <= cfg_wdata[PIXEL_W-1:0];
                REG_LEVEL_BRIGHT: level_bright_reg <= cfg_wdata[PIXEL_W-1:0];
                REG_PATTERN_CODE: pattern_code_reg <= cfg_wdata[PATTERN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stg_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            stg_pixel_reg <= s_pixel_value;
            stg_last_reg  <= s_last_pixel;
        end
    end

    // a new value closes the open run
    assign close_prev = run_open_reg && (stg_pixel_reg != run_value_reg);

    rcpd_close #(
        .PATTERN_LEN (PATTERN_LEN),
        .FILL_W      (FILL_W)
    ) u_close_prev (
        .win_in       (win_reg),
        .fill_in      (fill_reg),
        .found_in     (found_reg),
        .run_value    (run_value_reg),
        .level_dark   (level_dark_reg),
        .level_mid    (level_mid_reg),
        .level_bright (level_bright_reg),
        .pattern_code (pattern_code_reg),
        .win_out      (win_a),
        .fill_out     (fill_a),
        .found_out    (found_a)
    );

    assign win_mid   = close_prev ? win_a   : win_reg;
    assign fill_mid  = close_prev ? fill_a  : fill_reg;
    assign found_mid = close_prev ? found_a : found_reg;

    // final run of the line, closed on the last pixel
    rcpd_close #(
        .PATTERN_LEN (PATTERN_LEN),
        .FILL_W      (FILL_W)
    ) u_close_last (
        .win_in       (win_mid),
        .fill_in      (fill_mid),
        .found_in     (found_mid),
        .run_value    (stg_pixel_reg),
        .level_dark   (level_dark_reg),
        .level_mid    (level_mid_reg),
        .level_bright (level_bright_reg),
        .pattern_code (pattern_code_reg),
        .win_out      (win_b),
        .fill_out     (fill_b),
        .found_out    (found_b)
    );

    always_comb begin
        if (stg_last_reg) begin
            run_value_next = '0;
            run_open_next  = 1'b0;
            win_next       = '0;
            fill_next      = '0;
            found_next     = 1'b0;
        end else begin
            run_value_next = stg_pixel_reg;
            run_open_next  = 1'b1;
            win_next       = win_mid;
            fill_next      = fill_mid;
            found_next     = found_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_value_reg <= '0;
            run_open_reg  <= 1'b0;
            win_reg       <= '0;
            fill_reg      <= '0;
            found_reg     <= 1'b0;
        end else if (stg_advance) begin
            run_value_reg <= run_value_next;
            run_open_reg  <= run_open_next;
            win_reg       <= win_next;
            fill_reg      <= fill_next;
            found_reg     <= found_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= stg_valid_reg && stg_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && stg_valid_reg && stg_last_reg) begin
            m_found_reg <= found_b;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pattern_found = m_found_reg;

    `RCPD_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1,
        fill_reg <= FILL_W'(PATTERN_LEN), "window fill count past pattern length")
    `RCPD_ASSERT_NOW(a_found_needs_full, aclk, aresetn, found_reg,
        fill_reg == FILL_W'(PATTERN_LEN), "match flag set with partial window")
    `RCPD_ASSERT_NEXT(a_line_end_clears, aclk, aresetn, stg_advance && stg_last_reg,
        !run_open_reg && !found_reg && fill_reg == '0, "state not cleared after line end")
    `RCPD_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready,
        stg_valid_reg && stg_last_reg && m_valid_reg && !m_ready,
        "input stalled without a blocked result")
    `RCPD_ASSERT_NEXT(a_result_follows_last, aclk, aresetn, stg_advance && stg_last_reg,
        m_valid_reg, "no result word after last pixel")

endmodule
